// File: hw/rtl/osde_pkg.sv
// Package for the one-bit sign distance estimate unit.
// Holds payload structs, accumulator widths and the square-root status type.
// No dependencies.
package osde_pkg;

  localparam int unsigned CompW   = 16;  // vector component width
  localparam int unsigned MagW    = 17;  // magnitude of a centred component
  localparam int unsigned TermW   = 18;  // signed-sum term width
  localparam int unsigned SqW     = 45;  // squared-sum accumulators
  localparam int unsigned SumW    = 28;  // signed query sum
  localparam int unsigned InvW    = 16;  // Q0.16 reciprocal root of dimension
  localparam int unsigned NormW   = 23;  // floor(sqrt) of a 45-bit value
  localparam int unsigned EstW    = 46;  // result width
  localparam int unsigned MulW    = 28;  // shared multiplier operand width
  localparam int unsigned ProdW   = 51;  // widest product kept

  localparam logic [InvW-1:0] InvSqrtDimReset = 16'd5793;
  localparam logic [EstW-1:0] EstMax          = {EstW{1'b1}};

  typedef struct packed {
    logic signed [CompW-1:0] query_value;
    logic signed [CompW-1:0] data_value;
    logic signed [CompW-1:0] center_value;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [EstW-1:0] distance_estimate;
    logic            fallback_used;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// File: hw/rtl/osde_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on osde_pkg for widths and the status struct.
module osde_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [osde_pkg::SqW-1:0]        value_i,
  output logic [osde_pkg::NormW-1:0]      root_o,
  output osde_pkg::sqrt_stat_t            stat_o
);
  import osde_pkg::*;

  logic [SqW-1:0] v_q, v_d;
  logic [SqW-1:0] r_q, r_d;
  logic [SqW-1:0] bit_q, bit_d;
  logic           busy_q, done_q;
  logic [SqW:0]   trial;
  logic           take;

  // Classic restoring scheme: bit walks down by powers of four.
  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign take  = {1'b0, v_q} >= trial;

  always_comb begin
    v_d   = v_q;
    r_d   = r_q >> 1;
    bit_d = bit_q >> 2;
    if (take) begin
      v_d = v_q - trial[SqW-1:0];
      r_d = (r_q >> 1) + bit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= ~bit_q[0];
      done_q <= bit_q[0];
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= {1'b1, {(SqW-1){1'b0}}};
    end else if (busy_q) begin
      v_q   <= v_d;
      r_q   <= r_d;
      bit_q <= bit_d;
    end
  end

  assign root_o      = r_q[NormW-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: hw/rtl/one_bit_sign_distance_estimate_unit.sv
// Top level of the one-bit sign distance estimate unit: sequencer, shared
// multiplier, accumulators and output register. Uses osde_pkg and osde_isqrt.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------
//  in      | in  | in_valid_i / in_stall_o   | in_data_i  (osde_pkg::in_item_t)
//  out     | out | out_valid_o / out_stall_i | out_data_o (osde_pkg::out_item_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (inv_sqrt_dim, Q0.16)
//
// A dimension without the last mark takes a transfer, then two passes
// through the single 28x28 multiplier and a saturating add.
// A last dimension adds the kick and wait of the bit-serial square root, up to
// six multiply/add steps and one output load before the result.
// in_stall_o is high whenever the sequencer is busy; a stalled result holds
// the sequencer in its output state. Reset clears accumulators and sets
// inv_sqrt_dim to 5793. Config is taken in any cycle.
module one_bit_sign_distance_estimate_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  osde_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output osde_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [osde_pkg::InvW-1:0]     cfg_data_i
);
  import osde_pkg::*;

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;   // waiting for a transfer
  localparam logic [3:0] S_MQ   = 4'd1;   // query square, signed-sum update
  localparam logic [3:0] S_MX   = 4'd2;   // data square, query acc
  localparam logic [3:0] S_MA   = 4'd3;   // data acc
  localparam logic [3:0] S_SQS  = 4'd4;   // kick square root
  localparam logic [3:0] S_SQW  = 4'd5;   // wait for root
  localparam logic [3:0] S_P1   = 4'd6;   // fallback check, |sum| * inv
  localparam logic [3:0] S_P2   = 4'd7;   // norm * p_hi
  localparam logic [3:0] S_P3   = 4'd8;   // norm * p_lo
  localparam logic [3:0] S_P4   = 4'd9;   // rounding, q + d
  localparam logic [3:0] S_P5   = 4'd10;  // inner-product magnitude
  localparam logic [3:0] S_P6   = 4'd11;  // final combine and clamp
  localparam logic [3:0] S_OUT  = 4'd12;  // load output register

  logic [3:0]             state_q, state_d;
  logic [InvW-1:0]        inv_q;

  // per-dimension operands
  logic [MagW-1:0]        qm_q, xm_q;
  logic signed [TermW-1:0] term_q;
  logic                   last_q;

  // accumulators
  logic [SqW-1:0]         qsum_q, dsum_q;
  logic signed [SumW-1:0] ssum_q;

  // shared multiplier
  logic [MulW-1:0]        mul_a, mul_b;
  logic [2*MulW-1:0]      mul_full;
  logic [ProdW-1:0]       prod_q;

  // finishing datapath
  logic [NormW-1:0]       norm_q;
  logic [InvW-1:0]        plo_q;
  logic [ProdW-1:0]       hi_q;
  logic [NormW:0]         rnd_q;
  logic [EstW-1:0]        tsum_q;
  logic [ProdW:0]         ipm_q;
  logic [EstW-1:0]        est_q;
  logic                   fallback_q;

  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   in_xfer, out_load;
  logic signed [MagW-1:0] qc, xc;
  logic [MulW-1:0]        smag;
  logic [SqW:0]           qsum_add, dsum_add;
  logic signed [SumW:0]   ssum_add;
  logic [ProdW+1:0]       two_ip;
  logic [ProdW+2:0]       grow;

  logic                   sq_start;
  logic [NormW-1:0]       sq_root;
  sqrt_stat_t             sq_stat;

  osde_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (dsum_q),
    .root_o  (sq_root),
    .stat_o  (sq_stat)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign sq_start    = (state_q == S_SQS);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // centred components, exact in 17 bits
  assign qc = MagW'(in_data_i.query_value) - MagW'(in_data_i.center_value);
  assign xc = MagW'(in_data_i.data_value) - MagW'(in_data_i.center_value);

  assign smag = ssum_q[SumW-1] ? MulW'(-ssum_q) : MulW'(ssum_q);

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MQ: begin
        mul_a = MulW'(qm_q);
        mul_b = MulW'(qm_q);
      end
      S_MX: begin
        mul_a = MulW'(xm_q);
        mul_b = MulW'(xm_q);
      end
      S_P1: begin
        mul_a = smag;
        mul_b = MulW'(inv_q);
      end
      S_P2: begin
        mul_a = MulW'(norm_q);
        mul_b = MulW'(prod_q[43:16]);
      end
      S_P3: begin
        mul_a = MulW'(norm_q);
        mul_b = MulW'(plo_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // saturating adds; squares are at most 34 bits
  assign qsum_add = {1'b0, qsum_q} + (SqW+1)'(prod_q[2*MagW-1:0]);
  assign dsum_add = {1'b0, dsum_q} + (SqW+1)'(prod_q[2*MagW-1:0]);
  assign ssum_add = (SumW+1)'(ssum_q) + (SumW+1)'(term_q);

  // final combine: sum of squares minus or plus twice the estimate
  assign two_ip = {ipm_q, 1'b0};
  assign grow   = (ProdW+3)'(tsum_q) + (ProdW+3)'(two_ip);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_MQ;
      S_MQ:   state_d = S_MX;
      S_MX:   state_d = S_MA;
      S_MA:   state_d = last_q ? S_SQS : S_IDLE;
      S_SQS:  state_d = S_SQW;
      S_SQW:  if (sq_stat.done) state_d = S_P1;
      S_P1:   state_d = (norm_q == '0 || inv_q == '0) ? S_OUT : S_P2;
      S_P2:   state_d = S_P3;
      S_P3:   state_d = S_P4;
      S_P4:   state_d = S_P5;
      S_P5:   state_d = S_P6;
      S_P6:   state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inv_q       <= InvSqrtDimReset;
      qsum_q      <= '0;
      dsum_q      <= '0;
      ssum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        inv_q <= cfg_data_i;
      end
      if (state_q == S_MQ) begin
        if (ssum_add > (SumW+1)'(signed'({2'b00, {(SumW-1){1'b1}}}))) begin
          ssum_q <= {1'b0, {(SumW-1){1'b1}}};
        end else if (ssum_add < (SumW+1)'(signed'({2'b11, {(SumW-1){1'b0}}}))) begin
          ssum_q <= {1'b1, {(SumW-1){1'b0}}};
        end else begin
          ssum_q <= ssum_add[SumW-1:0];
        end
      end
      if (state_q == S_MX) begin
        qsum_q <= qsum_add[SqW] ? {SqW{1'b1}} : qsum_add[SqW-1:0];
      end
      if (state_q == S_MA) begin
        dsum_q <= dsum_add[SqW] ? {SqW{1'b1}} : dsum_add[SqW-1:0];
      end
      if (out_load) begin
        qsum_q <= '0;
        dsum_q <= '0;
        ssum_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      qm_q   <= qc[MagW-1] ? MagW'(-qc) : MagW'(qc);
      xm_q   <= xc[MagW-1] ? MagW'(-xc) : MagW'(xc);
      term_q <= xc[MagW-1] ? -TermW'(qc) : TermW'(qc);
      last_q <= in_data_i.last_element;
    end
    if (state_q == S_MQ || state_q == S_MX || state_q == S_P1 ||
        state_q == S_P2 || state_q == S_P3) begin
      prod_q <= mul_full[ProdW-1:0];
    end
    if (state_q == S_SQW && sq_stat.done) begin
      norm_q <= sq_root;
    end
    if (state_q == S_P1) begin
      fallback_q <= (norm_q == '0 || inv_q == '0);
      est_q      <= EstW'(qsum_q);
    end
    if (state_q == S_P2) begin
      plo_q <= prod_q[InvW-1:0];
    end
    if (state_q == S_P3) begin
      hi_q <= prod_q;
    end
    if (state_q == S_P4) begin
      // round half up on the low partial product
      rnd_q  <= (NormW+1)'((prod_q[NormW+InvW-1:0] + (NormW+InvW+1)'(16'h8000)) >> 16);
      tsum_q <= EstW'(qsum_q) + EstW'(dsum_q);
    end
    if (state_q == S_P5) begin
      ipm_q <= (ProdW+1)'(hi_q) + (ProdW+1)'(rnd_q);
    end
    if (state_q == S_P6) begin
      if (ssum_q[SumW-1]) begin
        est_q <= (grow > (ProdW+3)'(EstMax)) ? EstMax : grow[EstW-1:0];
      end else begin
        est_q <= (two_ip > (ProdW+2)'(tsum_q)) ? '0 : tsum_q - two_ip[EstW-1:0];
      end
    end
    if (out_load) begin
      out_q.distance_estimate <= est_q;
      out_q.fallback_used     <= fallback_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a plain dimension goes round the loop through MQ, MX and MA back to idle
  a_plain_dim_turnaround: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !in_data_i.last_element |-> ##4 state_q == S_IDLE)
    else $error("plain dimension did not return to idle in four cycles");

  // root completion only seen while the sequencer waits for it
  a_root_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> state_q == S_SQW)
    else $error("square root finished outside the wait state");

  // accumulators are fresh once a result is loaded
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> qsum_q == '0 && dsum_q == '0 && ssum_q == '0)
    else $error("accumulators not cleared after a result");

  // a non-fallback result must have come through a non-zero norm
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !fallback_q |-> norm_q != '0 && inv_q != '0)
    else $error("estimate path used with zero norm or zero reciprocal");

  // the root unit is idle whenever an item can be taken
  a_root_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sq_stat.busy)
    else $error("square root busy while the unit is idle");

endmodule
